### rtl/arprr_pkg.sv
// ----------------------------------------------------------------------------
// arprr_pkg
// Types and codes shared by the ARP receive path and its resolution table.
// ----------------------------------------------------------------------------
package arprr_pkg;

    typedef enum logic [3:0] {
        ST_REPLY       = 4'd0,
        ST_BAD_HW      = 4'd1,
        ST_BAD_PROTO   = 4'd2,
        ST_MALFORMED   = 4'd3,
        ST_NOT_FOR_US  = 4'd4,
        ST_UNSOLICITED = 4'd5,
        ST_RESOLVED    = 4'd6,
        ST_UNKNOWN_OP  = 4'd7,
        ST_INSERTED    = 4'd8,
        ST_FULL        = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EVAL,
        FSM_SCAN,
        FSM_DONE
    } fsm_state_t;

    typedef enum logic {
        CMD_PACKET = 1'b0,
        CMD_INSERT = 1'b1
    } cmd_t;

    // one table slot: reachable flag above the IPv4 address
    typedef struct packed {
        logic        reachable;
        logic [31:0] ip;
    } slot_t;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_LEN      = 8'd6;
    localparam logic [7:0]  PROTO_LEN   = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;

    // register index, taken from paddr[3]
    localparam logic REG_OWN_MAC = 1'b0;
    localparam logic REG_OWN_IP  = 1'b1;

endpackage

### rtl/arprr_table.sv
// ----------------------------------------------------------------------------
// arprr_table
// Resolution table store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module arprr_table #(
    parameter int unsigned TABLE_ENTRIES = 16,
    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  arprr_pkg::slot_t      wr_data,
    input  logic [IDX_W-1:0]      rd_addr,
    output arprr_pkg::slot_t      rd_data
);

    arprr_pkg::slot_t mem [TABLE_ENTRIES];
    arprr_pkg::slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/arp_receive_and_resolve_table.sv
// ----------------------------------------------------------------------------
// arp_receive_and_resolve_table
// Checks parsed ARP packets, builds reply fields for requests to own_ip,
// resolves incomplete table entries on replies and inserts new entries.
// ----------------------------------------------------------------------------
// Inserts and packets other than ARP replies go from FSM_EVAL straight to
// FSM_DONE; ARP replies with a non-empty table first pass through FSM_SCAN,
// the newest-to-oldest scan through the table's single read port.
// s_axis_tready is low while a request is in progress. Reset clears control
// state and slots_used; table contents are undefined until written and need
// no clearing pass.
// ----------------------------------------------------------------------------
module arp_receive_and_resolve_table #(
    parameter int unsigned TABLE_ENTRIES = 16,
    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES),
    localparam int unsigned SU_W  = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic         aclk,
    input  logic         aresetn,

    // hw_type, net_type, hw_len, proto_len, operation,
    // sender_mac, sender_ip, tgt_ip, lookup_ip
    input  logic [207:0] s_axis_tdata,
    // cmd
    input  logic [0:0]   s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,

    // reply_dest_mac, reply_sender_mac, reply_sender_ip, reply_target_mac,
    // reply_tgt_ip, entry_index, resolved_mac, 4 bits zero pad
    output logic [263:0] m_axis_tdata,
    // status
    output logic [3:0]   m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    // configuration
    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3])
                arprr_pkg::REG_OWN_MAC: own_mac_reg <= pwdata[47:0];
                arprr_pkg::REG_OWN_IP:  own_ip_reg  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            arprr_pkg::REG_OWN_MAC: prdata = {16'd0, own_mac_reg};
            arprr_pkg::REG_OWN_IP:  prdata = {32'd0, own_ip_reg};
            default:                prdata = '0;
        endcase
    end

    // captured request
    arprr_pkg::cmd_t in_cmd_reg;
    logic [15:0] in_hw_type_reg;
    logic [15:0] in_net_type_reg;
    logic [7:0]  in_hw_len_reg;
    logic [7:0]  in_proto_len_reg;
    logic [15:0] in_op_reg;
    logic [47:0] in_sender_mac_reg;
    logic [31:0] in_sender_ip_reg;
    logic [31:0] in_tgt_ip_reg;
    logic [31:0] in_lookup_ip_reg;

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_cmd_reg        <= arprr_pkg::cmd_t'(s_axis_tuser[0]);
            in_hw_type_reg    <= s_axis_tdata[15:0];
            in_net_type_reg   <= s_axis_tdata[31:16];
            in_hw_len_reg     <= s_axis_tdata[39:32];
            in_proto_len_reg  <= s_axis_tdata[47:40];
            in_op_reg         <= s_axis_tdata[63:48];
            in_sender_mac_reg <= s_axis_tdata[111:64];
            in_sender_ip_reg  <= s_axis_tdata[143:112];
            in_tgt_ip_reg     <= s_axis_tdata[175:144];
            in_lookup_ip_reg  <= s_axis_tdata[207:176];
        end
    end

    // sequencer
    arprr_pkg::fsm_state_t state_reg, state_next;
    logic [SU_W-1:0]  slots_used_reg, slots_used_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             chk_valid_reg, chk_valid_next;
    arprr_pkg::status_t res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;

    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_wr_addr;
    arprr_pkg::slot_t tbl_wr_data;
    logic [IDX_W-1:0] tbl_rd_addr;
    arprr_pkg::slot_t tbl_rd_data;
    logic [SU_W-1:0]  newest;
    logic             out_free;
    logic             out_load;

    assign newest        = slots_used_reg - 1'b1;
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (state_reg == arprr_pkg::FSM_IDLE);
    assign tbl_rd_addr   = scan_idx_reg;

    always_comb begin
        state_next      = state_reg;
        slots_used_next = slots_used_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        chk_idx_next    = chk_idx_reg;
        chk_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        tbl_wr_en       = 1'b0;
        tbl_wr_addr     = slots_used_reg[IDX_W-1:0];
        tbl_wr_data     = '{reachable: 1'b0, ip: in_lookup_ip_reg};
        out_load        = 1'b0;

        case (state_reg)
            arprr_pkg::FSM_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = arprr_pkg::FSM_EVAL;
                end
            end

            arprr_pkg::FSM_EVAL: begin
                state_next   = arprr_pkg::FSM_DONE;
                res_idx_next = '0;
                if (in_cmd_reg == arprr_pkg::CMD_INSERT) begin
                    if (slots_used_reg == SU_W'(TABLE_ENTRIES)) begin
                        res_status_next = arprr_pkg::ST_FULL;
                    end else begin
                        tbl_wr_en       = 1'b1;
                        res_status_next = arprr_pkg::ST_INSERTED;
                        res_idx_next    = slots_used_reg[IDX_W-1:0];
                        slots_used_next = slots_used_reg + 1'b1;
                    end
                end else if (in_hw_type_reg != arprr_pkg::HW_ETHERNET) begin
                    res_status_next = arprr_pkg::ST_BAD_HW;
                end else if (in_net_type_reg != arprr_pkg::PROTO_IPV4) begin
                    res_status_next = arprr_pkg::ST_BAD_PROTO;
                end else if (in_proto_len_reg != arprr_pkg::PROTO_LEN ||
                             in_hw_len_reg != arprr_pkg::HW_LEN) begin
                    res_status_next = arprr_pkg::ST_MALFORMED;
                end else if (in_op_reg == arprr_pkg::OP_REQUEST) begin
                    if (in_tgt_ip_reg != own_ip_reg) begin
                        res_status_next = arprr_pkg::ST_NOT_FOR_US;
                    end else begin
                        res_status_next = arprr_pkg::ST_REPLY;
                    end
                end else if (in_op_reg == arprr_pkg::OP_REPLY) begin
                    res_status_next = arprr_pkg::ST_UNSOLICITED;
                    if (slots_used_reg != '0) begin
                        state_next      = arprr_pkg::FSM_SCAN;
                        scan_idx_next   = newest[IDX_W-1:0];
                        issue_done_next = 1'b0;
                    end
                end else begin
                    res_status_next = arprr_pkg::ST_UNKNOWN_OP;
                end
            end

            arprr_pkg::FSM_SCAN: begin
                if (chk_valid_reg && tbl_rd_data.ip == in_sender_ip_reg) begin
                    state_next = arprr_pkg::FSM_DONE;
                    if (!tbl_rd_data.reachable) begin
                        tbl_wr_en       = 1'b1;
                        tbl_wr_addr     = chk_idx_reg;
                        tbl_wr_data     = '{reachable: 1'b1, ip: in_sender_ip_reg};
                        res_status_next = arprr_pkg::ST_RESOLVED;
                        res_idx_next    = chk_idx_reg;
                    end
                end else if (chk_valid_reg && chk_idx_reg == '0) begin
                    state_next = arprr_pkg::FSM_DONE;
                end else begin
                    chk_valid_next = !issue_done_reg;
                    chk_idx_next   = scan_idx_reg;
                    if (scan_idx_reg == '0) begin
                        issue_done_next = 1'b1;
                    end else begin
                        scan_idx_next = scan_idx_reg - 1'b1;
                    end
                end
            end

            arprr_pkg::FSM_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = arprr_pkg::FSM_IDLE;
                end
            end

            default: begin
                state_next = arprr_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= arprr_pkg::FSM_IDLE;
            slots_used_reg <= '0;
            issue_done_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slots_used_reg <= slots_used_next;
            issue_done_reg <= issue_done_next;
            chk_valid_reg  <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
    end

    arprr_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // output register
    logic        out_valid_reg;
    logic [3:0]  out_status_reg;
    logic [47:0] out_dest_mac_reg;
    logic [47:0] out_snd_mac_reg;
    logic [31:0] out_snd_ip_reg;
    logic [47:0] out_tgt_mac_reg;
    logic [31:0] out_tgt_ip_reg;
    logic [3:0]  out_index_reg;
    logic [47:0] out_res_mac_reg;
    logic        is_reply;
    logic        is_indexed;

    assign is_reply   = (res_status_reg == arprr_pkg::ST_REPLY);
    assign is_indexed = (res_status_reg == arprr_pkg::ST_RESOLVED) ||
                        (res_status_reg == arprr_pkg::ST_INSERTED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg   <= res_status_reg;
            out_dest_mac_reg <= is_reply ? in_sender_mac_reg : 48'd0;
            out_snd_mac_reg  <= is_reply ? own_mac_reg : 48'd0;
            out_snd_ip_reg   <= is_reply ? in_tgt_ip_reg : 32'd0;
            out_tgt_mac_reg  <= is_reply ? in_sender_mac_reg : 48'd0;
            out_tgt_ip_reg   <= is_reply ? in_sender_ip_reg : 32'd0;
            out_index_reg    <= is_indexed ? 4'(res_idx_reg) : 4'd0;
            out_res_mac_reg  <= (res_status_reg == arprr_pkg::ST_RESOLVED) ?
                                in_sender_mac_reg : 48'd0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {4'd0, out_res_mac_reg, out_index_reg, out_tgt_ip_reg,
                            out_tgt_mac_reg, out_snd_ip_reg, out_snd_mac_reg,
                            out_dest_mac_reg};

endmodule
